/* design/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types, constants and helpers of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int CFG_W  = 13;
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  // signed range of one gradient: -1020..1020
  localparam int GRAD_W = 11;

  // line store entry: newest row in the upper byte, older row in the lower
  localparam int LINE_W = 2 * PIX_W;

  // result kinds of one input word, in emission order
  localparam int NUM_EMIT    = 4;
  localparam int EMIT_MAIN   = 0;  // (r-1, c-1)
  localparam int EMIT_RIGHT  = 1;  // right border (r-1, W-1)
  localparam int EMIT_BOTTOM = 2;  // bottom border (H-1, c-1)
  localparam int EMIT_CORNER = 3;  // bottom right corner (H-1, W-1)

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // per-word tag carried from the counters to the result sequencer
  typedef struct packed {
    logic [NUM_EMIT-1:0] emit;
    logic                interior;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } sem_tag_t;

  // width minus one, with the width clamped to 3..MAX_WIDTH
  function automatic logic [COL_W-1:0] width_last(input logic [WCFG_W-1:0] v);
    logic [COL_W-1:0] res;
    if (v < WCFG_W'(3)) begin
      res = COL_W'(2);
    end else if (v > WCFG_W'(MAX_WIDTH)) begin
      res = COL_W'(MAX_WIDTH - 1);
    end else begin
      res = COL_W'(v - WCFG_W'(1));
    end
    return res;
  endfunction

  // height minus one, with the height clamped to 3..MAX_HEIGHT
  function automatic logic [ROW_W-1:0] height_last(input logic [HCFG_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (v < HCFG_W'(3)) begin
      res = ROW_W'(2);
    end else if (v > HCFG_W'(MAX_HEIGHT)) begin
      res = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      res = ROW_W'(v - HCFG_W'(1));
    end
    return res;
  endfunction

  // |gx| + |gy| saturated to one pixel
  function automatic logic [PIX_W-1:0] mag_sat(input logic signed [GRAD_W-1:0] gx,
                                                input logic signed [GRAD_W-1:0] gy);
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    logic [GRAD_W:0]   sum;
    logic [PIX_W-1:0]  res;
    ax  = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
    ay  = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
    sum = {1'b0, ax} + {1'b0, ay};
    if (sum > (GRAD_W+1)'(255)) begin
      res = '1;
    end else begin
      res = sum[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/sem_line_ram.sv */
// ----------------------------------------------------------------------------
// sem_line_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sem_window.sv */
// ----------------------------------------------------------------------------
// sem_window
// 3x3 pixel window and registered Sobel gradients of the newest window.
// ----------------------------------------------------------------------------
module sem_window import sem_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift,
  input  logic [PIX_W-1:0]         px,
  input  logic [PIX_W-1:0]         up1,
  input  logic [PIX_W-1:0]         up2,
  output logic signed [GRAD_W-1:0] gx,
  output logic signed [GRAD_W-1:0] gy
);

  logic [PIX_W-1:0] win      [9];
  logic [PIX_W-1:0] win_next [9];
  logic [PIX_W+1:0] sum_l, sum_r, sum_t, sum_b;

  // shift left by one column, new column from the line stores and the input
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i*3+0] = win[i*3+1];
      win_next[i*3+1] = win[i*3+2];
    end
    win_next[2] = up2;
    win_next[5] = up1;
    win_next[8] = px;
  end

  // weighted 1,2,1 sums of the outer columns and rows
  always_comb begin
    sum_l = {2'b0, win_next[0]} + {1'b0, win_next[3], 1'b0} + {2'b0, win_next[6]};
    sum_r = {2'b0, win_next[2]} + {1'b0, win_next[5], 1'b0} + {2'b0, win_next[8]};
    sum_t = {2'b0, win_next[0]} + {1'b0, win_next[1], 1'b0} + {2'b0, win_next[2]};
    sum_b = {2'b0, win_next[6]} + {1'b0, win_next[7], 1'b0} + {2'b0, win_next[8]};
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      win <= win_next;
    end
  end

  // gradients of the window just formed
  always_ff @(posedge clk) begin
    if (shift) begin
      gx <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
      gy <= $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    end
  end

endmodule

/* design/sem_emit.sv */
// ----------------------------------------------------------------------------
// sem_emit
// Result sequencer: sends the up to four results of one word through one
// output register, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module sem_emit import sem_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  sem_tag_t                 tag,
  input  logic signed [GRAD_W-1:0] gx,
  input  logic signed [GRAD_W-1:0] gy,
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  output logic [PIX_W-1:0]         magnitude,
  output logic                     last_of_run
);

  logic [NUM_EMIT-1:0] pend;
  logic [NUM_EMIT-1:0] pend_next;
  logic                interior;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic                out_free;
  logic                fire;
  logic [ROW_W-1:0]    res_row;
  logic [COL_W-1:0]    res_col;
  logic [PIX_W-1:0]    res_mag;

  assign out_free = !out_valid || out_ready;
  assign fire     = (pend != '0) && out_free;

  // first pending result kind and what stays after it
  always_comb begin
    pend_next = pend;
    res_row   = row;
    res_col   = col;
    res_mag   = '0;
    priority if (pend[EMIT_MAIN]) begin
      pend_next[EMIT_MAIN] = 1'b0;
      res_row = row - ROW_W'(1);
      res_col = col - COL_W'(1);
      res_mag = interior ? mag_sat(gx, gy) : '0;
    end else if (pend[EMIT_RIGHT]) begin
      pend_next[EMIT_RIGHT] = 1'b0;
      res_row = row - ROW_W'(1);
    end else if (pend[EMIT_BOTTOM]) begin
      pend_next[EMIT_BOTTOM] = 1'b0;
      res_col = col - COL_W'(1);
    end else if (pend[EMIT_CORNER]) begin
      pend_next[EMIT_CORNER] = 1'b0;
    end else begin
      pend_next = '0;
    end
  end

  // free for the next word once the last result of this one goes out
  assign take = (pend == '0) || (fire && (pend_next == '0));

  // pending kinds of the word in work
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= tag.emit;
    end else if (fire) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      interior <= tag.interior;
      row      <= tag.row;
      col      <= tag.col;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_row     <= res_row;
      out_col     <= res_col;
      magnitude   <= res_mag;
      last_of_run <= (pend_next == '0);
    end
  end

endmodule

/* design/sobel_edge_magnitude.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude |gx|+|gy| on 8-bit grey frames.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at one per clock while in_ready is high. The two
// previous rows sit in one 1024 x 16 simple dual port line store: each pixel
// reads its column as it is accepted and writes it back when it moves on to
// the window. Results leave through a single output register at one per clock
// while out_ready is high. A pixel causes one result in the frame body, two at
// the last column and on the last row, four at the last pixel of a frame, none
// in row 0 or column 0. A result word passes the read stage, the result
// sequencer and the output register. Border results carry magnitude zero.
// Writing the width or height register restarts the frame at row 0, column 0;
// sizes are clamped to 3..1024 and 3..4096. No clearing pass after reset.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude import sem_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   out_row,
  output logic [COL_W-1:0]   out_col,
  output logic [PIX_W-1:0]   magnitude,
  output logic               last_of_run,
  input  logic               cfg_we,
  input  cfg_reg_t           cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic [COL_W-1:0]        width_m1;
  logic [ROW_W-1:0]        height_m1;
  logic [COL_W-1:0]        col;
  logic [ROW_W-1:0]        row;
  logic                    in_fire;
  sem_tag_t                tag_in;

  logic                    s1_valid;
  sem_tag_t                s1_tag;
  logic [PIX_W-1:0]        s1_px;
  logic                    s1_go;
  logic                    s1_fwd;
  logic [LINE_W-1:0]       s1_fwd_data;
  logic [LINE_W-1:0]       ram_q;
  logic [LINE_W-1:0]       line_word;
  logic [PIX_W-1:0]        up1;
  logic [PIX_W-1:0]        up2;

  logic                    emit_take;
  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;

  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;
  assign s1_go    = s1_valid && emit_take;

  // frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= COL_W'(640 - 1);
      height_m1 <= ROW_W'(480 - 1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_m1  <= width_last(cfg_data[WCFG_W-1:0]);
        REG_HEIGHT: height_m1 <= height_last(cfg_data[HCFG_W-1:0]);
      endcase
    end
  end

  // raster position of the next input word
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (col == width_m1) begin
        col <= '0;
        row <= (row == height_m1) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // result kinds caused by this position
  always_comb begin
    tag_in                   = '0;
    tag_in.row               = row;
    tag_in.col               = col;
    tag_in.interior          = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    tag_in.emit[EMIT_MAIN]   = (row != '0) && (col != '0);
    tag_in.emit[EMIT_RIGHT]  = (row != '0) && (col == width_m1);
    tag_in.emit[EMIT_BOTTOM] = (row == height_m1) && (col != '0);
    tag_in.emit[EMIT_CORNER] = (row == height_m1) && (col == width_m1);
  end

  // line store read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tag <= tag_in;
      s1_px  <= pixel;
      // bypass a write-back to the column being read in the same cycle
      s1_fwd      <= s1_go && (s1_tag.col == col);
      s1_fwd_data <= {s1_px, up1};
    end
  end

  assign line_word = s1_fwd ? s1_fwd_data : ram_q;
  assign up1       = line_word[LINE_W-1:PIX_W];
  assign up2       = line_word[PIX_W-1:0];

  sem_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LINE_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_tag.col),
    .wdata ({s1_px, up1}),
    .re    (in_fire),
    .raddr (col),
    .rdata (ram_q)
  );

  sem_window u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_go),
    .px    (s1_px),
    .up1   (up1),
    .up2   (up2),
    .gx    (gx),
    .gy    (gy)
  );

  sem_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_go),
    .tag         (s1_tag),
    .gx          (gx),
    .gy          (gy),
    .take        (emit_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .magnitude   (magnitude),
    .last_of_run (last_of_run)
  );

endmodule

/* design/sem_checker.sv */
// ----------------------------------------------------------------------------
// sem_checker
// Port level checks of the Sobel edge magnitude block, bound to the top.
// ----------------------------------------------------------------------------
module sem_checker import sem_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [PIX_W-1:0] pixel,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_row,
  input logic [COL_W-1:0] out_col,
  input logic [PIX_W-1:0] magnitude,
  input logic             last_of_run
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word shown right after reset");

  // waiting pixel word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(pixel))
    else $error("waiting pixel word changed");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(magnitude) && $stable(last_of_run))
    else $error("stalled result word changed");

  // a run of results goes out without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("gap inside a run of results");

  // top and left border results carry zero magnitude
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (magnitude != '0) |-> (out_row != '0) && (out_col != '0))
    else $error("nonzero magnitude on the top or left border");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .pixel       (pixel),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_row     (out_row),
  .out_col     (out_col),
  .magnitude   (magnitude),
  .last_of_run (last_of_run)
);

/* bench/sobel_edge_checker.sv */
// ----------------------------------------------------------------------------
// sobel_edge_checker
// Watches the pixel, result and register ports of the Sobel edge magnitude
// block, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module sobel_edge_checker import sem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [PIX_W-1:0] pixel,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [ROW_W-1:0] out_row,
  input  logic [COL_W-1:0] out_col,
  input  logic [PIX_W-1:0] magnitude,
  input  logic             last_of_run,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatch_count,
  output int               edges_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] mag;
    logic             last;
  } edge_word_t;

  // shadow of the block: sizes, two previous rows, 3x3 window, raster position
  logic [WCFG_W-1:0] width_reg;
  logic [HCFG_W-1:0] height_reg;
  logic [PIX_W-1:0]  recent_line [MAX_WIDTH];
  logic [PIX_W-1:0]  older_line  [MAX_WIDTH];
  logic [PIX_W-1:0]  win [9];
  int unsigned       row_pos;
  int unsigned       col_pos;
  edge_word_t        expected_edges [$];

  function automatic int unsigned effective_size(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // |gx| + |gy| over the current window, clipped to one pixel
  function automatic logic [PIX_W-1:0] sobel_magnitude();
    int gx;
    int gy;
    int sum;
    gx = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
       - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
    gy = int'(win[6]) + 2 * int'(win[7]) + int'(win[8])
       - int'(win[0]) - 2 * int'(win[1]) - int'(win[2]);
    sum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
    return (sum > 255) ? 8'hFF : sum[PIX_W-1:0];
  endfunction

  function automatic edge_word_t make_word(input int unsigned row, input int unsigned col,
                                           input logic [PIX_W-1:0] mag);
    edge_word_t wd;
    wd.row  = ROW_W'(row);
    wd.col  = COL_W'(col);
    wd.mag  = mag;
    wd.last = 1'b0;
    return wd;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_v);
    mismatch_count++;
    $display("[%0t] mismatch: %s, got %0d, expected %0d", $time, what, got, want_v);
  endtask

  // advance the shadow by one pixel and queue the words it releases
  task automatic absorb_pixel(input logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      r;
    int unsigned      c;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
    logic [PIX_W-1:0] mag;
    edge_word_t       run [4];
    int               n;
    int               i;
    w = effective_size(width_reg, MAX_WIDTH);
    h = effective_size(height_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    n = 0;
    up1 = recent_line[c];
    up2 = older_line[c];
    older_line[c]  = up1;
    recent_line[c] = px;
    for (i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;

    // centre pixel, then right border, bottom border and corner
    if (r >= 1 && c >= 1) begin
      mag = (r >= 2 && c >= 2) ? sobel_magnitude() : '0;
      run[n] = make_word(r - 1, c - 1, mag);
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      run[n] = make_word(r - 1, w - 1, '0);
      n++;
    end
    if (r == h - 1 && c >= 1) begin
      run[n] = make_word(h - 1, c - 1, '0);
      n++;
    end
    if (r == h - 1 && c == w - 1) begin
      run[n] = make_word(h - 1, w - 1, '0);
      n++;
    end
    if (n > 0) begin
      run[n-1].last = 1'b1;
    end
    for (i = 0; i < n; i++) begin
      expected_edges.push_back(run[i]);
    end

    // raster position
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  always @(posedge clk) begin
    edge_word_t want;
    if (rst) begin
      width_reg  = WCFG_W'(640);
      height_reg = HCFG_W'(480);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        recent_line[i] = '0;
        older_line[i]  = '0;
      end
      for (int i = 0; i < 9; i++) begin
        win[i] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      expected_edges.delete();
      mismatch_count = 0;
    end else begin
      // result word against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("word at (%0d,%0d) with nothing expected", out_row, out_col),
                          magnitude, 0);
        end else begin
          want = expected_edges.pop_front();
          if (out_row !== want.row)
            report_mismatch($sformatf("out_row of (%0d,%0d)", want.row, want.col),
                            out_row, want.row);
          if (out_col !== want.col)
            report_mismatch($sformatf("out_col of (%0d,%0d)", want.row, want.col),
                            out_col, want.col);
          if (magnitude !== want.mag)
            report_mismatch($sformatf("magnitude of (%0d,%0d)", want.row, want.col),
                            magnitude, want.mag);
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run of (%0d,%0d)", want.row, want.col),
                            last_of_run, want.last);
        end
      end

      // register write restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg  = cfg_data[WCFG_W-1:0];
          REG_HEIGHT: height_reg = cfg_data[HCFG_W-1:0];
        endcase
        row_pos = 0;
        col_pos = 0;
      end

      if (in_valid && in_ready) begin
        absorb_pixel(pixel);
      end
    end
    edges_pending <= expected_edges.size();
  end

endmodule

/* bench/tb_sobel_edge_magnitude.sv */
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude
// Streams frames of several sizes through the Sobel edge magnitude block with
// random gaps and stalls; a side checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude import sem_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // directed frames at 3x3: strong vertical edge, flat white, faint corner
  localparam logic [27*PIX_W-1:0] DIRECTED_PIXELS = {
    8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd10,  8'd10,  8'd10,  8'd10,  8'd20,  8'd10,  8'd10,  8'd10,  8'd13
  };

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] pixel;
  logic             out_valid;
  logic             out_ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] magnitude;
  logic             last_of_run;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               mismatch_count;
  int               edges_pending;

  bit               idle_on;
  int               stall_requests;

  sobel_edge_magnitude dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .magnitude   (magnitude),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  sobel_edge_checker edge_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .magnitude      (magnitude),
    .last_of_run    (last_of_run),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .edges_pending  (edges_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int draw_gap();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(0, 18));
  endfunction

  // mostly uniform, a quarter of the time black or white
  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // stall_at asks the receiver for a long hold-off at that pixel of the run
  task automatic send_run(input int count, input int stall_at);
    for (int i = 0; i < count; i++) begin
      if (i == stall_at) stall_requests++;
      send_pixel(random_pixel());
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and let every expected word come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (edges_pending != 0);
    repeat (10) @(posedge clk);
  endtask

  // result side: random ready gaps, long hold-off on request
  initial begin
    int gap;
    int stalls_served;
    out_ready <= 1'b0;
    stalls_served = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (stalls_served != stall_requests) begin
        stalls_served++;
        gap = 400;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // stimulus
  initial begin
    int               fw;
    int               fh;
    int               npx;
    int               random_items;
    logic [CFG_W-1:0] wdata;
    logic [CFG_W-1:0] hdata;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    pixel     <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data  <= '0;
    idle_on        = 1'b0;
    stall_requests = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed 3x3 frames; width written with junk above bit 10
    write_reg(REG_WIDTH, 13'h1803);
    write_reg(REG_HEIGHT, 13'd2);
    for (int i = 0; i < 27; i++) begin
      send_pixel(DIRECTED_PIXELS[PIX_W*(26-i) +: PIX_W]);
    end
    drain();

    // all-ones height clamps; long output hold-off while pixels keep coming
    write_reg(REG_WIDTH, 13'd8);
    write_reg(REG_HEIGHT, 13'h1FFF);
    send_run(40, 12);
    drain();

    // small random frames, some cut short by the next size write
    random_items = 0;
    while (random_items < 120) begin
      wdata   = CFG_W'($urandom_range(0, 10));
      hdata   = CFG_W'($urandom_range(0, 6));
      fw      = (wdata < 3) ? 3 : int'(wdata);
      fh      = (hdata < 3) ? 3 : int'(hdata);
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        write_reg(REG_WIDTH, wdata);
        write_reg(REG_HEIGHT, hdata);
      end else begin
        write_reg(REG_HEIGHT, hdata);
        write_reg(REG_WIDTH, wdata);
      end
      npx = fw * fh * int'($urandom_range(1, 2));
      if ($urandom_range(0, 3) == 0) npx = int'($urandom_range(1, fw * fh - 1));
      send_run(npx, -1);
      random_items += npx;
      drain();
    end

    if (mismatch_count == 0 && edges_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sem_pkg.sv
design/sem_line_ram.sv
design/sem_window.sv
design/sem_emit.sv
design/sobel_edge_magnitude.sv
design/sem_checker.sv
bench/sobel_edge_checker.sv
bench/tb_sobel_edge_magnitude.sv
